// File: hw/rtl/rslt_pkg.sv
// Shared constants for the race start light timer.
`timescale 1ns / 1ps
package rslt_pkg;

  localparam int unsigned CFG_W       = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned ELAPSED_W   = 24;
  localparam int unsigned TIME_BITS_D = 24;

  localparam logic [CFG_W-1:0] RED_MS_RST      = 16'd1000;
  localparam logic [CFG_W-1:0] YELLOW_MS_RST   = 16'd3000;
  localparam logic [CFG_W-1:0] DEBOUNCE_MS_RST = 16'd10000;

  localparam logic [CFG_IDX_W-1:0] REG_RED_MS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_YELLOW_MS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS = 2'd2;

endpackage

// File: hw/rtl/rslt_if.sv
// Valid/ready channel interfaces for tick items and result items.
`timescale 1ns / 1ps
interface rslt_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic reset_req;
  logic barrier_edge;

  modport source (output valid, output start_req, output reset_req, output barrier_edge,
                  input ready);
  modport sink (input valid, input start_req, input reset_req, input barrier_edge,
                output ready);
endinterface

interface rslt_out_if;
  logic                           valid;
  logic                           ready;
  logic                           red_lamp;
  logic                           yellow_lamp;
  logic                           green_lamp;
  logic [1:0]                     phase;
  logic [rslt_pkg::ELAPSED_W-1:0] elapsed_ms;
  logic                           false_start;
  logic                           finish_pulse;

  modport source (output valid, output red_lamp, output yellow_lamp, output green_lamp,
                  output phase, output elapsed_ms, output false_start,
                  output finish_pulse, input ready);
  modport sink (input valid, input red_lamp, input yellow_lamp, input green_lamp,
                input phase, input elapsed_ms, input false_start, input finish_pulse,
                output ready);
endinterface

// File: hw/rtl/race_start_light_timer.sv
// Top level of the race start light timer: tick handling, state and result register.
`timescale 1ns / 1ps
// Each tick item updates the race state in the cycle it transfers and its result
// appears in the output register on the next cycle; a new tick is taken every cycle
// while the result register is empty or being drained, so throughput is one item
// per clock. Configuration writes take effect on the next tick and belong in idle
// periods.
module race_start_light_timer #(
  parameter int unsigned TIME_BITS = rslt_pkg::TIME_BITS_D
) (
  input  logic                           clk,
  input  logic                           rst_n,
  rslt_in_if.sink                        in_ch,
  rslt_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [rslt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rslt_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int unsigned CW = rslt_pkg::CFG_W;
  localparam int unsigned EW = rslt_pkg::ELAPSED_W;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_LIGHTS = 2'd1,
    PH_RUN    = 2'd2,
    PH_FIN    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    STEP_RED   = 2'd0,
    STEP_RY    = 2'd1,
    STEP_GREEN = 2'd2
  } step_t;

  logic [CW-1:0]        red_ms_r, yellow_ms_r, debounce_ms_r;
  phase_t               phase_r, phase_nxt;
  step_t                step_r, step_nxt;
  logic [CW-1:0]        ltimer_r, ltimer_nxt, ltimer_inc;
  logic [TIME_BITS-1:0] rtime_r, rtime_nxt;
  logic [CW-1:0]        slc_r, slc_nxt;
  logic                 accepted, fs_nxt, fin_nxt;
  logic                 red_nxt, yel_nxt, grn_nxt;
  logic [32:0]          rtime_ext;
  logic [EW-1:0]        shown_nxt;

  logic                 out_valid_r;
  logic                 red_r, yel_r, grn_r, fs_r, fin_r;
  phase_t               out_phase_r;
  logic [EW-1:0]        elapsed_r;
  logic                 in_fire;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign ltimer_inc  = ltimer_r + CW'(1);

  always_comb begin
    accepted   = 1'b0;
    fs_nxt     = 1'b0;
    fin_nxt    = 1'b0;
    slc_nxt    = slc_r;
    phase_nxt  = phase_r;
    step_nxt   = step_r;
    ltimer_nxt = ltimer_r;
    rtime_nxt  = rtime_r;

    if (in_ch.barrier_edge && slc_r >= debounce_ms_r) begin
      accepted = 1'b1;
      slc_nxt  = '0;
    end else if (slc_r != '1) begin
      slc_nxt = slc_r + CW'(1);
    end

    if (in_ch.reset_req) begin
      phase_nxt  = PH_IDLE;
      step_nxt   = STEP_RED;
      ltimer_nxt = '0;
      rtime_nxt  = '0;
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
          if (in_ch.start_req) begin
            phase_nxt  = PH_LIGHTS;
            step_nxt   = STEP_RED;
            ltimer_nxt = '0;
            rtime_nxt  = '0;
          end
        end
        PH_LIGHTS: begin
          if (accepted && step_r != STEP_GREEN) begin
            phase_nxt  = PH_IDLE;
            step_nxt   = STEP_RED;
            ltimer_nxt = '0;
            rtime_nxt  = '0;
            fs_nxt     = 1'b1;
          end else if (accepted) begin
            phase_nxt = PH_RUN;
            rtime_nxt = '0;
          end else if (step_r == STEP_RED) begin
            ltimer_nxt = ltimer_inc;
            if (ltimer_inc >= red_ms_r) begin
              step_nxt   = STEP_RY;
              ltimer_nxt = '0;
            end
          end else if (step_r == STEP_RY) begin
            ltimer_nxt = ltimer_inc;
            if (ltimer_inc >= yellow_ms_r) begin
              step_nxt   = STEP_GREEN;
              ltimer_nxt = '0;
            end
          end
        end
        PH_RUN: begin
          if (rtime_r != '1) begin
            rtime_nxt = rtime_r + TIME_BITS'(1);
          end
          if (accepted) begin
            phase_nxt = PH_FIN;
            fin_nxt   = 1'b1;
          end
        end
        PH_FIN: begin
        end
        default: begin
        end
      endcase
    end

    red_nxt = (phase_nxt != PH_IDLE) && (step_nxt == STEP_RED || step_nxt == STEP_RY);
    yel_nxt = (phase_nxt != PH_IDLE) && (step_nxt == STEP_RY);
    grn_nxt = (phase_nxt != PH_IDLE) && (step_nxt != STEP_RED) && (step_nxt != STEP_RY);

    rtime_ext = 33'(rtime_nxt);
    shown_nxt = (rtime_ext > 33'({EW{1'b1}})) ? {EW{1'b1}} : rtime_ext[EW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_ms_r      <= rslt_pkg::RED_MS_RST;
      yellow_ms_r   <= rslt_pkg::YELLOW_MS_RST;
      debounce_ms_r <= rslt_pkg::DEBOUNCE_MS_RST;
      phase_r       <= PH_IDLE;
      step_r        <= STEP_RED;
      ltimer_r      <= '0;
      rtime_r       <= '0;
      slc_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          rslt_pkg::REG_RED_MS:      red_ms_r      <= cfg_wdata;
          rslt_pkg::REG_YELLOW_MS:   yellow_ms_r   <= cfg_wdata;
          rslt_pkg::REG_DEBOUNCE_MS: debounce_ms_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (in_fire) begin
        phase_r     <= phase_nxt;
        step_r      <= step_nxt;
        ltimer_r    <= ltimer_nxt;
        rtime_r     <= rtime_nxt;
        slc_r       <= slc_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      red_r       <= red_nxt;
      yel_r       <= yel_nxt;
      grn_r       <= grn_nxt;
      out_phase_r <= phase_nxt;
      elapsed_r   <= shown_nxt;
      fs_r        <= fs_nxt;
      fin_r       <= fin_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.red_lamp     = red_r;
  assign out_ch.yellow_lamp  = yel_r;
  assign out_ch.green_lamp   = grn_r;
  assign out_ch.phase        = 2'(out_phase_r);
  assign out_ch.elapsed_ms   = elapsed_r;
  assign out_ch.false_start  = fs_r;
  assign out_ch.finish_pulse = fin_r;

  a_pulse_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(fs_r && fin_r))
    else $error("false start and finish in one result");

  a_idle_dark: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_phase_r == PH_IDLE) |-> (!red_r && !yel_r && !grn_r))
    else $error("lamps lit in idle");

  a_green_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && grn_r) |-> (!red_r && !yel_r))
    else $error("green shown with red or yellow");

  a_reset_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.reset_req) |=> (phase_r == PH_IDLE && rtime_r == '0))
    else $error("reset request did not return to idle");

  a_time_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE || phase_r == PH_LIGHTS) |-> (rtime_r == '0))
    else $error("race time nonzero before the race");

endmodule

// File: dv/tb_race_start_light_timer.sv
// Testbench for the race start light timer: directed and random tick traffic checked against a tick predictor.
`timescale 1ns / 1ps
module tb_race_start_light_timer;

  localparam logic [rslt_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int IDLE_LIMIT = 4000;
  localparam int unsigned RT_W = rslt_pkg::TIME_BITS_D;

  typedef enum logic [1:0] {PH_IDLE, PH_LIGHTS, PH_RUN, PH_FIN} race_phase_e;
  typedef enum logic [1:0] {STEP_RED, STEP_RY, STEP_GREEN} light_step_e;

  typedef struct packed {
    logic start_req;
    logic reset_req;
    logic barrier_edge;
  } tick_t;

  typedef struct packed {
    logic                           red_lamp;
    logic                           yellow_lamp;
    logic                           green_lamp;
    race_phase_e                    phase;
    logic [rslt_pkg::ELAPSED_W-1:0] elapsed_ms;
    logic                           false_start;
    logic                           finish_pulse;
  } readout_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [rslt_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rslt_pkg::CFG_W-1:0]     cfg_wdata;

  rslt_in_if  tick_if ();
  rslt_out_if readout_if ();

  race_start_light_timer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (tick_if),
    .out_ch    (readout_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  logic [rslt_pkg::CFG_W-1:0] red_dur;
  logic [rslt_pkg::CFG_W-1:0] yellow_dur;
  logic [rslt_pkg::CFG_W-1:0] debounce_dur;
  race_phase_e                race_phase;
  light_step_e                light_step;
  logic [15:0]                light_timer;
  logic [RT_W-1:0]            race_clock;
  logic [15:0]                since_crossing;

  tick_t    tick_q[$];
  readout_t readout_q[$];
  tick_t    next_tick;
  int       ticks_queued;
  int       ticks_sent;
  int       readouts_seen;
  int       mismatch_count;
  int       send_gap;
  int       send_steady;
  int       recv_hold;
  int       recv_steady;
  bit       backlog_forced;
  int       stalled_cycles;

  always #1 clk = ~clk;

  function automatic void clear_race();
    race_phase  = PH_IDLE;
    light_step  = STEP_RED;
    light_timer = '0;
    race_clock  = '0;
  endfunction

  function automatic readout_t advance_race_tick(tick_t t);
    readout_t r;
    logic     accepted;
    r = '0;
    accepted = t.barrier_edge && (since_crossing >= debounce_dur);
    if (accepted) begin
      since_crossing = '0;
    end else if (since_crossing != 16'hFFFF) begin
      since_crossing = since_crossing + 16'd1;
    end
    if (t.reset_req) begin
      clear_race();
    end else begin
      case (race_phase)
        PH_IDLE: begin
          if (t.start_req) begin
            race_phase  = PH_LIGHTS;
            light_step  = STEP_RED;
            light_timer = '0;
            race_clock  = '0;
          end
        end
        PH_LIGHTS: begin
          if (accepted && light_step != STEP_GREEN) begin
            clear_race();
            r.false_start = 1'b1;
          end else if (accepted) begin
            race_phase = PH_RUN;
            race_clock = '0;
          end else if (light_step == STEP_RED) begin
            light_timer = light_timer + 16'd1;
            if (light_timer >= red_dur) begin
              light_step  = STEP_RY;
              light_timer = '0;
            end
          end else if (light_step == STEP_RY) begin
            light_timer = light_timer + 16'd1;
            if (light_timer >= yellow_dur) begin
              light_step  = STEP_GREEN;
              light_timer = '0;
            end
          end
        end
        PH_RUN: begin
          if (race_clock != '1) race_clock = race_clock + RT_W'(1);
          if (accepted) begin
            race_phase     = PH_FIN;
            r.finish_pulse = 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (race_phase != PH_IDLE) begin
      case (light_step)
        STEP_RED: r.red_lamp = 1'b1;
        STEP_RY: begin
          r.red_lamp    = 1'b1;
          r.yellow_lamp = 1'b1;
        end
        default: r.green_lamp = 1'b1;
      endcase
    end
    r.phase      = race_phase;
    r.elapsed_ms = race_clock;
    return r;
  endfunction

  function automatic int draw_gap(inout int steady);
    int r;
    if (steady > 0) begin
      steady--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      steady = $urandom_range(40, 150);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic log_mismatch(string msg);
    $display("mismatch at readout %0d: %s", readouts_seen, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) log_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic push_tick(logic s, logic c, logic b);
    tick_q.push_back('{start_req: s, reset_req: c, barrier_edge: b});
    ticks_queued++;
  endtask

  task automatic settle();
    while (ticks_sent != ticks_queued || readout_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [rslt_pkg::CFG_IDX_W-1:0] idx,
                           logic [rslt_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      rslt_pkg::REG_RED_MS:      red_dur = val;
      rslt_pkg::REG_YELLOW_MS:   yellow_dur = val;
      rslt_pkg::REG_DEBOUNCE_MS: debounce_dur = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_lights(logic [rslt_pkg::CFG_W-1:0] r,
                                logic [rslt_pkg::CFG_W-1:0] y,
                                logic [rslt_pkg::CFG_W-1:0] d);
    settle();
    write_reg(rslt_pkg::REG_RED_MS, r);
    write_reg(rslt_pkg::REG_YELLOW_MS, y);
    write_reg(rslt_pkg::REG_DEBOUNCE_MS, d);
  endtask

  // one race attempt from idle, ending in a reset tick
  task automatic queue_race();
    int lights_n;
    int hold_n;
    int run_n;
    lights_n = int'(red_dur) + int'(yellow_dur);
    hold_n   = (int'(debounce_dur) > 40) ? 40 : int'(debounce_dur);
    push_tick(1'b1, 1'b0, $urandom_range(0, 7) == 0);
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(0, lights_n)) push_tick(1'($urandom_range(0, 1)), 1'b0, 1'b0);
      push_tick(1'b0, 1'b0, 1'b1);
    end else begin
      run_n = lights_n + $urandom_range(0, 3);
      if (run_n < hold_n) run_n = hold_n;
      repeat (run_n) push_tick(1'($urandom_range(0, 1)), 1'b0, $urandom_range(0, 19) == 0);
      push_tick(1'($urandom_range(0, 1)), 1'b0, 1'b1);
      run_n = $urandom_range(0, 20);
      if (run_n < hold_n) run_n = hold_n;
      repeat (run_n) push_tick(1'($urandom_range(0, 1)), 1'b0, 1'b0);
      push_tick(1'($urandom_range(0, 1)), 1'b0, 1'b1);
      repeat ($urandom_range(0, 3)) push_tick(1'($urandom_range(0, 1)), 1'b0,
                                              1'($urandom_range(0, 1)));
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 4)) push_tick(1'($urandom_range(0, 1)),
                                              1'($urandom_range(0, 1)),
                                              1'($urandom_range(0, 1)));
    end
    push_tick(1'($urandom_range(0, 1)), 1'b1, 1'($urandom_range(0, 1)));
  endtask

  // tick driver
  always @(posedge clk) begin
    if (!rst_n) begin
      tick_if.valid <= 1'b0;
    end else begin
      if (tick_if.valid && tick_if.ready) begin
        readout_q.push_back(advance_race_tick({tick_if.start_req, tick_if.reset_req,
                                               tick_if.barrier_edge}));
        ticks_sent++;
      end
      if (!tick_if.valid || tick_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          tick_if.valid <= 1'b0;
        end else if (tick_q.size() != 0) begin
          next_tick = tick_q.pop_front();
          tick_if.valid        <= 1'b1;
          tick_if.start_req    <= next_tick.start_req;
          tick_if.reset_req    <= next_tick.reset_req;
          tick_if.barrier_edge <= next_tick.barrier_edge;
          send_gap = draw_gap(send_steady);
        end else begin
          tick_if.valid <= 1'b0;
        end
      end
    end
  end

  // readout backpressure, with one long hold to fill the block
  always @(posedge clk) begin
    if (!rst_n) begin
      readout_if.ready <= 1'b0;
    end else if (recv_hold > 0) begin
      recv_hold--;
      readout_if.ready <= 1'b0;
    end else if (!backlog_forced && readouts_seen >= 200) begin
      backlog_forced = 1'b1;
      recv_hold = $urandom_range(150, 300);
      readout_if.ready <= 1'b0;
    end else begin
      recv_hold = draw_gap(recv_steady);
      readout_if.ready <= 1'b1;
    end
  end

  // readout monitor
  always @(posedge clk) begin
    readout_t want;
    if (rst_n && readout_if.valid && readout_if.ready) begin
      readouts_seen++;
      if (readout_q.size() == 0) begin
        log_mismatch("readout with no tick pending");
      end else begin
        want = readout_q.pop_front();
        check_field("red_lamp", 32'(readout_if.red_lamp), 32'(want.red_lamp));
        check_field("yellow_lamp", 32'(readout_if.yellow_lamp), 32'(want.yellow_lamp));
        check_field("green_lamp", 32'(readout_if.green_lamp), 32'(want.green_lamp));
        check_field("phase", 32'(readout_if.phase), 32'(want.phase));
        check_field("elapsed_ms", 32'(readout_if.elapsed_ms), 32'(want.elapsed_ms));
        check_field("false_start", 32'(readout_if.false_start), 32'(want.false_start));
        check_field("finish_pulse", 32'(readout_if.finish_pulse), 32'(want.finish_pulse));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((tick_if.valid && tick_if.ready) || (readout_if.valid && readout_if.ready)) begin
        stalled_cycles = 0;
      end else begin
        stalled_cycles++;
        if (stalled_cycles >= IDLE_LIMIT) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  initial begin
    int base;
    clk                  = 1'b0;
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = rslt_pkg::REG_RED_MS;
    cfg_wdata            = '0;
    tick_if.valid        = 1'b0;
    tick_if.start_req    = 1'b0;
    tick_if.reset_req    = 1'b0;
    tick_if.barrier_edge = 1'b0;
    readout_if.ready     = 1'b0;
    red_dur              = rslt_pkg::RED_MS_RST;
    yellow_dur           = rslt_pkg::YELLOW_MS_RST;
    debounce_dur         = rslt_pkg::DEBOUNCE_MS_RST;
    since_crossing       = '0;
    clear_race();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: long debounce rejects every edge
    push_tick(1'b0, 1'b0, 1'b0);
    push_tick(1'b0, 1'b0, 1'b1);
    push_tick(1'b1, 1'b0, 1'b1);
    push_tick(1'b0, 1'b0, 1'b0);
    push_tick(1'b1, 1'b1, 1'b1);

    program_lights(16'd2, 16'd3, 16'd0);
    write_reg(REG_SPARE, 16'hFFFF);
    // false start at red, then at red plus yellow
    push_tick(1'b1, 1'b0, 1'b0);
    push_tick(1'b0, 1'b0, 1'b1);
    push_tick(1'b1, 1'b0, 1'b0);
    push_tick(1'b0, 1'b0, 1'b0);
    push_tick(1'b0, 1'b0, 1'b0);
    push_tick(1'b0, 1'b0, 1'b1);
    // full race, then edge and start while finished, then reset
    push_tick(1'b1, 1'b0, 1'b0);
    repeat (5) push_tick(1'b0, 1'b0, 1'b0);
    push_tick(1'b0, 1'b0, 1'b1);
    push_tick(1'b0, 1'b0, 1'b0);
    push_tick(1'b0, 1'b0, 1'b0);
    push_tick(1'b0, 1'b0, 1'b1);
    push_tick(1'b0, 1'b0, 1'b1);
    push_tick(1'b1, 1'b0, 1'b0);
    push_tick(1'b0, 1'b1, 1'b0);
    push_tick(1'b1, 1'b0, 1'b0);
    push_tick(1'b0, 1'b1, 1'b0);

    for (int k = 0; k < 6; k++) begin
      case (k)
        0: program_lights(16'd1, 16'd1, 16'd0);
        1: program_lights(16'd0, 16'd0, 16'd1);
        4: program_lights(16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)), 16'hFFFF);
        default: program_lights(16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
                                16'($urandom_range(0, 12)));
      endcase
      base = ticks_queued;
      while (ticks_queued - base < 130) queue_race();
    end

    // longest light steps; an edge deep in the red step is a false start
    program_lights(16'hFFFF, 16'hFFFF, 16'd0);
    push_tick(1'b0, 1'b1, 1'b0);
    push_tick(1'b1, 1'b0, 1'b0);
    repeat (20) push_tick(1'b0, 1'b0, 1'b0);
    push_tick(1'b0, 1'b0, 1'b1);
    repeat (5) push_tick(1'b0, 1'b0, 1'b0);
    push_tick(1'b0, 1'b1, 1'b0);

    settle();
    repeat (5) @(posedge clk);
    if (mismatch_count == 0 && readout_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/rslt_pkg.sv
hw/rtl/rslt_if.sv
hw/rtl/race_start_light_timer.sv
dv/tb_race_start_light_timer.sv
